[rtl/efr_pkg.sv]
package efr_pkg;

  // Default largest frame, in stored bytes
  localparam int unsigned MAX_FRAME_DEF = 32;

  // Config register indexes
  localparam logic [1:0] REG_START_CODE     = 2'd0;
  localparam logic [1:0] REG_END_CODE       = 2'd1;
  localparam logic [1:0] REG_ESCAPE_CODE    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_RELOAD = 2'd3;

  // Config reset values
  localparam logic [7:0] START_CODE_RST     = 8'h02;
  localparam logic [7:0] END_CODE_RST       = 8'h03;
  localparam logic [7:0] ESCAPE_CODE_RST    = 8'h10;
  localparam logic [7:0] TIMEOUT_RELOAD_RST = 8'hFF;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_READY   = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_e;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] timeout_reload;
  } cfg_t;

  // Receiver state apart from the write position (its width follows MAX_FRAME)
  typedef struct packed {
    logic       assembling;
    logic       esc_pending;
    logic       frame_ready;
    logic [7:0] ticks_left;
    logic [7:0] timeouts;
    logic       dropped;
  } rx_state_t;

  typedef struct packed {
    logic       valid;
    event_e     kind;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic [5:0] frame_length;
    logic       overflowed;
    logic [7:0] timeout_count;
  } result_t;

endpackage

[rtl/efr_step.sv]
module efr_step #(
  parameter int unsigned MAX_FRAME = efr_pkg::MAX_FRAME_DEF,
  localparam int unsigned PosW     = $clog2(MAX_FRAME + 1)
) (
  input  efr_pkg::cfg_t      cfg_i,
  input  efr_pkg::rx_state_t state_i,
  input  logic [PosW-1:0]    pos_i,
  input  logic [1:0]         command_i,
  input  logic [7:0]         rx_byte_i,
  output efr_pkg::rx_state_t state_o,
  output logic [PosW-1:0]    pos_o,
  output efr_pkg::result_t   result_o
);

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME);
  localparam logic [PosW-1:0] PosOne = PosW'(1);

  logic is_start, is_end, is_esc;
  logic unesc_start, unesc_end, unesc_escape;

  assign is_start     = (rx_byte_i == cfg_i.start_code);
  assign is_end       = (rx_byte_i == cfg_i.end_code);
  assign is_esc       = (rx_byte_i == cfg_i.escape_code);
  // start beats end beats escape when codes collide
  assign unesc_start  = !state_i.esc_pending && is_start;
  assign unesc_end    = !state_i.esc_pending && !is_start && is_end;
  assign unesc_escape = !state_i.esc_pending && !is_start && !is_end && is_esc;

  always_comb begin
    state_o  = state_i;
    pos_o    = pos_i;
    result_o = '0;
    result_o.kind = efr_pkg::EV_BYTE;

    unique case (command_i)
      efr_pkg::CMD_BYTE: begin
        if (!state_i.frame_ready) begin
          priority if (unesc_end) begin
            state_o.esc_pending = 1'b0;
            state_o.assembling  = 1'b0;
            state_o.frame_ready = 1'b1;
            result_o.valid      = 1'b1;
            result_o.kind       = efr_pkg::EV_READY;
          end else if (unesc_escape) begin
            state_o.esc_pending = 1'b1;
          end else if (unesc_start || !state_i.assembling) begin
            // (re)start; escaped start while waiting also starts
            state_o.esc_pending = 1'b0;
            if (is_start) begin
              state_o.assembling = 1'b1;
              state_o.ticks_left = cfg_i.timeout_reload;
              state_o.dropped    = 1'b0;
              pos_o              = '0;
            end
          end else if (pos_i < MaxPos) begin
            state_o.esc_pending = 1'b0;
            pos_o               = pos_i + PosOne;
            result_o.valid      = 1'b1;
            result_o.kind       = efr_pkg::EV_BYTE;
            result_o.byte_index = 5'(pos_i);
            result_o.data_byte  = rx_byte_i;
          end else begin
            state_o.esc_pending = 1'b0;
            state_o.dropped     = 1'b1;
          end
        end
      end
      efr_pkg::CMD_TICK: begin
        if (state_i.assembling) begin
          if (state_i.ticks_left == 8'd0) begin
            state_o.timeouts   = state_i.timeouts + 8'd1;
            state_o.assembling = 1'b0;
            result_o.valid     = 1'b1;
            result_o.kind      = efr_pkg::EV_TIMEOUT;
          end else begin
            state_o.ticks_left = state_i.ticks_left - 8'd1;
          end
        end
      end
      efr_pkg::CMD_RELEASE: begin
        state_o.frame_ready = 1'b0;
      end
      default: ;
    endcase

    // status fields reflect the state after this item
    result_o.frame_length  = 6'(pos_o);
    result_o.overflowed    = state_o.dropped;
    result_o.timeout_count = state_o.timeouts;
  end

endmodule

[rtl/escaped_frame_receiver_unit.sv]
// Byte-stuffed frame receiver: one command per cycle while the event output is not stalled.
// A result is registered in the output register and appears in the cycle after
// its command transfer; the state update is a single combinational pass.
// Throughput: one input transfer per cycle; the output register is the only
// stage, so input stalls only while a result sits unaccepted.
// Reset (rst_ni low, async): config back to defaults, receiver idle, counts 0.
module escaped_frame_receiver_unit #(
  parameter int unsigned MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // command channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  // event channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_kind_o,
  output logic [4:0] byte_index_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] frame_length_o,
  output logic       overflowed_o,
  output logic [7:0] timeout_count_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME + 1);

  efr_pkg::cfg_t      cfg_q;
  efr_pkg::rx_state_t state_q, state_d;
  logic [PosW-1:0]    pos_q, pos_d;
  efr_pkg::result_t   res_d, res_q;
  logic               out_valid_q, out_valid_d;
  logic               in_fire;

  // Config registers; the user must write them only while idle, the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code     <= efr_pkg::START_CODE_RST;
      cfg_q.end_code       <= efr_pkg::END_CODE_RST;
      cfg_q.escape_code    <= efr_pkg::ESCAPE_CODE_RST;
      cfg_q.timeout_reload <= efr_pkg::TIMEOUT_RELOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        efr_pkg::REG_START_CODE:     cfg_q.start_code     <= cfg_wdata_i;
        efr_pkg::REG_END_CODE:       cfg_q.end_code       <= cfg_wdata_i;
        efr_pkg::REG_ESCAPE_CODE:    cfg_q.escape_code    <= cfg_wdata_i;
        efr_pkg::REG_TIMEOUT_RELOAD: cfg_q.timeout_reload <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state and event for the command at the input
  efr_step #(
    .MAX_FRAME (MAX_FRAME)
  ) u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .pos_i     (pos_q),
    .command_i (command_i),
    .rx_byte_i (rx_byte_i),
    .state_o   (state_d),
    .pos_o     (pos_d),
    .result_o  (res_d)
  );

  // Take a new command whenever the output register is free or draining now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      pos_q   <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // Output register: holds an event until its transfer.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire) begin
      out_valid_d = res_d.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && res_d.valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = res_q.kind;
  assign byte_index_o    = res_q.byte_index;
  assign data_byte_o     = res_q.data_byte;
  assign frame_length_o  = res_q.frame_length;
  assign overflowed_o    = res_q.overflowed;
  assign timeout_count_o = res_q.timeout_count;

  // A ready frame is never still being assembled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.frame_ready |-> !state_q.assembling)
    else $error("frame ready while assembling");

  // Write position never passes the frame limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_FRAME))
    else $error("write position past limit");

  // Bytes are only dropped once the frame is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dropped |-> (pos_q == PosW'(MAX_FRAME)))
    else $error("drop flag set below limit");

  // A timeout event bumps the counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.valid && res_d.kind == efr_pkg::EV_TIMEOUT)
      |=> (state_q.timeouts == $past(state_q.timeouts) + 8'd1))
    else $error("timeout count not bumped");

  // No event is lost: a stalled output stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled event lost or changed");

endmodule
